/* design/scoped_prefix_map_stack_top_assert.svh */
// assertion macros for the scoped prefix map stack
`ifndef SCOPED_PREFIX_MAP_STACK_TOP_ASSERT_SVH
`define SCOPED_PREFIX_MAP_STACK_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SPMS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spms assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SPMS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spms assertion failed");

`endif

/* design/spms_pkg.sv */
package spms_pkg;

  localparam int REQ_BITS    = 3;
  localparam int PREFIX_BITS = 10;
  localparam int URI_BITS    = 16;
  localparam int SEARCH_BITS = 6;
  localparam int LEVEL_BITS  = 7;
  localparam int STATUS_BITS = 3;

  localparam logic [REQ_BITS-1:0] REQ_PUSH   = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_POP    = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_ADD    = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_LOOKUP = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_NO_LEVEL  = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_BAD_LEVEL = 3'd4;

  typedef struct packed {
    logic [REQ_BITS-1:0]    req_type;
    logic [PREFIX_BITS-1:0] prefix_id;
    logic [URI_BITS-1:0]    uri_id;
    logic [SEARCH_BITS-1:0] search_level;
  } spms_req_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0]  level_index;
    logic [URI_BITS-1:0]    found_uri;
    logic                   matched;
    logic [STATUS_BITS-1:0] status;
  } spms_rsp_t;

  typedef struct packed {
    logic [PREFIX_BITS-1:0] prefix;
    logic [URI_BITS-1:0]    uri;
  } spms_bind_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_TAKE,
    DP_PUSH,
    DP_POP,
    DP_POP_LOAD,
    DP_ADD,
    DP_CLEAR,
    DP_LK_TOP,
    DP_LK_CNT,
    DP_LK_END,
    DP_LK_START,
    DP_SCAN_RD,
    DP_LK_NEXT
  } spms_op_e;

  typedef enum logic [1:0] {
    URI_ZERO,
    URI_EMPTY,
    URI_HIT
  } spms_uri_sel_e;

  typedef struct packed {
    spms_op_e               op;
    logic                   res_load;
    logic                   res_depth;
    spms_uri_sel_e          res_uri;
    logic [STATUS_BITS-1:0] res_status;
  } spms_cmd_t;

  typedef struct packed {
    logic [REQ_BITS-1:0] req_type;
    logic                prefix_zero;
    logic                depth_zero;
    logic                depth_full;
    logic                count_full;
    logic                level_bad;
    logic                level_top;
    logic                scan_hit;
    logic                scan_more;
    logic                level_zero;
    logic                out_busy;
  } spms_stat_t;

endpackage

/* design/spms_ram.sv */
module spms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/spms_ctrl.sv */
module spms_ctrl
  import spms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  spms_stat_t stat_i,
  output spms_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_POP      = 3'd2;
  localparam logic [2:0] S_LK_END   = 3'd3;
  localparam logic [2:0] S_LK_START = 3'd4;
  localparam logic [2:0] S_SCAN     = 3'd5;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d            = state_q;
    cmd_o.op           = DP_NOP;
    cmd_o.res_load     = 1'b0;
    cmd_o.res_depth    = 1'b0;
    cmd_o.res_uri      = URI_ZERO;
    cmd_o.res_status   = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_TAKE;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat_i.out_busy) begin
          state_d = S_IDLE;
          case (stat_i.req_type)
            REQ_PUSH: begin
              cmd_o.res_load  = 1'b1;
              cmd_o.res_depth = 1'b1;
              if (stat_i.depth_full) begin
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.op = DP_PUSH;
              end
            end
            REQ_POP: begin
              if (stat_i.depth_zero) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_UNDERFLOW;
              end else begin
                cmd_o.op = DP_POP;
                state_d  = S_POP;
              end
            end
            REQ_ADD: begin
              cmd_o.res_load = 1'b1;
              if (stat_i.depth_zero) begin
                cmd_o.res_status = ST_NO_LEVEL;
              end else if (stat_i.count_full) begin
                cmd_o.res_status = ST_FULL;
              end else begin
                cmd_o.op = DP_ADD;
              end
            end
            REQ_LOOKUP: begin
              if (stat_i.prefix_zero) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_uri  = URI_EMPTY;
              end else if (stat_i.level_bad) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_uri    = URI_EMPTY;
                cmd_o.res_status = ST_BAD_LEVEL;
              end else if (stat_i.level_top) begin
                cmd_o.op = DP_LK_CNT;
                state_d  = S_LK_START;
              end else begin
                cmd_o.op = DP_LK_TOP;
                state_d  = S_LK_END;
              end
            end
            REQ_CLEAR: begin
              cmd_o.op       = DP_CLEAR;
              cmd_o.res_load = 1'b1;
            end
            default: begin
              cmd_o.res_load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        cmd_o.op        = DP_POP_LOAD;
        cmd_o.res_load  = 1'b1;
        cmd_o.res_depth = 1'b1;
        state_d         = S_IDLE;
      end
      S_LK_END: begin
        cmd_o.op = DP_LK_END;
        state_d  = S_LK_START;
      end
      S_LK_START: begin
        cmd_o.op = DP_LK_START;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_hit) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_uri  = URI_HIT;
          state_d        = S_IDLE;
        end else if (stat_i.scan_more) begin
          cmd_o.op = DP_SCAN_RD;
        end else if (stat_i.level_zero) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_uri  = URI_EMPTY;
          state_d        = S_IDLE;
        end else begin
          cmd_o.op = DP_LK_NEXT;
          state_d  = S_LK_START;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* design/spms_dp.sv */
module spms_dp
  import spms_pkg::*;
#(
  parameter int MAX_LEVELS   = 64,
  parameter int MAX_BINDINGS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spms_req_t           in_data_i,
  input  logic                cfg_valid_i,
  input  logic [URI_BITS-1:0] cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output spms_rsp_t           out_data_o,
  input  spms_cmd_t           cmd_i,
  output spms_stat_t          stat_o
);

  localparam int DW  = $clog2(MAX_LEVELS + 1);
  localparam int LAW = $clog2(MAX_LEVELS);
  localparam int BW  = $clog2(MAX_BINDINGS + 1);
  localparam int BAW = $clog2(MAX_BINDINGS);
  localparam int CW  = (DW > SEARCH_BITS + 1) ? DW : SEARCH_BITS + 1;

  spms_req_t           req_q;
  logic [DW-1:0]       depth_q, depth_d;
  logic [BW-1:0]       count_q, count_d;
  logic [LAW-1:0]      lvl_q, lvl_d;
  logic [BW-1:0]       idx_q, idx_d;
  logic [BW-1:0]       start_q, start_d;
  logic [BW-1:0]       end_q, end_d;
  logic                pend_q, pend_d;
  logic [URI_BITS-1:0] empty_ns_q;
  spms_rsp_t           rsp_q;
  logic                out_valid_q;

  logic                ls_wr_en;
  logic                ls_rd_en;
  logic [LAW-1:0]      ls_rd_addr;
  logic [BW-1:0]       ls_rd_data;
  logic                bind_wr_en;
  logic                bind_rd_en;
  spms_bind_t          bind_wr_data;
  logic [PREFIX_BITS+URI_BITS-1:0] bind_rd_raw;
  spms_bind_t          bind_rd;

  logic [CW-1:0]       search_ext;
  logic [CW-1:0]       search_nxt;
  logic [CW-1:0]       depth_ext;

  assign search_ext = CW'(req_q.search_level);
  assign search_nxt = search_ext + CW'(1);
  assign depth_ext  = CW'(depth_q);
  assign bind_rd    = bind_rd_raw;

  assign bind_wr_data.prefix = req_q.prefix_id;
  assign bind_wr_data.uri    = req_q.uri_id;

  always_comb begin
    depth_d    = depth_q;
    count_d    = count_q;
    lvl_d      = lvl_q;
    idx_d      = idx_q;
    start_d    = start_q;
    end_d      = end_q;
    pend_d     = pend_q;
    ls_wr_en   = 1'b0;
    ls_rd_en   = 1'b0;
    ls_rd_addr = lvl_q;
    bind_wr_en = 1'b0;
    bind_rd_en = 1'b0;
    case (cmd_i.op)
      DP_PUSH: begin
        ls_wr_en = 1'b1;
        depth_d  = depth_q + DW'(1);
      end
      DP_POP: begin
        depth_d    = depth_q - DW'(1);
        ls_rd_en   = 1'b1;
        ls_rd_addr = LAW'(depth_q - DW'(1));
      end
      DP_POP_LOAD: begin
        count_d = ls_rd_data;
      end
      DP_ADD: begin
        bind_wr_en = 1'b1;
        count_d    = count_q + BW'(1);
      end
      DP_CLEAR: begin
        depth_d = '0;
        count_d = '0;
      end
      DP_LK_TOP: begin
        lvl_d      = LAW'(search_ext);
        ls_rd_en   = 1'b1;
        ls_rd_addr = LAW'(search_nxt);
      end
      DP_LK_CNT: begin
        lvl_d      = LAW'(search_ext);
        end_d      = count_q;
        ls_rd_en   = 1'b1;
        ls_rd_addr = LAW'(search_ext);
      end
      DP_LK_END: begin
        end_d    = ls_rd_data;
        ls_rd_en = 1'b1;
      end
      DP_LK_START: begin
        idx_d   = ls_rd_data;
        start_d = ls_rd_data;
        pend_d  = 1'b0;
      end
      DP_SCAN_RD: begin
        bind_rd_en = 1'b1;
        idx_d      = idx_q + BW'(1);
        pend_d     = 1'b1;
      end
      DP_LK_NEXT: begin
        lvl_d      = lvl_q - LAW'(1);
        end_d      = start_q;
        ls_rd_en   = 1'b1;
        ls_rd_addr = lvl_q - LAW'(1);
        pend_d     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      empty_ns_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      if (cfg_valid_i) begin
        empty_ns_q <= cfg_data_i;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q   <= lvl_d;
    idx_q   <= idx_d;
    start_q <= start_d;
    end_q   <= end_d;
    if (cmd_i.op == DP_TAKE) begin
      req_q <= in_data_i;
    end
    if (cmd_i.res_load) begin
      rsp_q.level_index <= cmd_i.res_depth ? LEVEL_BITS'(depth_q) : '0;
      rsp_q.matched     <= (cmd_i.res_uri == URI_HIT);
      rsp_q.status      <= cmd_i.res_status;
      case (cmd_i.res_uri)
        URI_EMPTY: rsp_q.found_uri <= empty_ns_q;
        URI_HIT:   rsp_q.found_uri <= bind_rd.uri;
        default:   rsp_q.found_uri <= '0;
      endcase
    end
  end

  // level start store: first binding slot of each open level
  spms_ram #(
    .WIDTH(BW),
    .DEPTH(MAX_LEVELS)
  ) u_level_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ls_wr_en),
    .wr_addr_i(LAW'(depth_q)),
    .wr_data_i(count_q),
    .rd_en_i  (ls_rd_en),
    .rd_addr_i(ls_rd_addr),
    .rd_data_o(ls_rd_data)
  );

  spms_ram #(
    .WIDTH(PREFIX_BITS + URI_BITS),
    .DEPTH(MAX_BINDINGS)
  ) u_bind_ram (
    .clk_i    (clk_i),
    .wr_en_i  (bind_wr_en),
    .wr_addr_i(BAW'(count_q)),
    .wr_data_i(bind_wr_data),
    .rd_en_i  (bind_rd_en),
    .rd_addr_i(BAW'(idx_q)),
    .rd_data_o(bind_rd_raw)
  );

  assign stat_o.req_type    = req_q.req_type;
  assign stat_o.prefix_zero = (req_q.prefix_id == '0);
  assign stat_o.depth_zero  = (depth_q == '0);
  assign stat_o.depth_full  = (depth_q == DW'(MAX_LEVELS));
  assign stat_o.count_full  = (count_q == BW'(MAX_BINDINGS));
  assign stat_o.level_bad   = (search_ext >= depth_ext);
  assign stat_o.level_top   = (search_nxt >= depth_ext);
  assign stat_o.scan_hit    = pend_q && (bind_rd.prefix == req_q.prefix_id);
  assign stat_o.scan_more   = (idx_q < end_q);
  assign stat_o.level_zero  = (lvl_q == '0);
  assign stat_o.out_busy    = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

endmodule

/* design/scoped_prefix_map_stack_top.sv */
// push, add, clear, unused codes: result loaded at decode; pop: level store read at decode and
// result loaded in the pop state; lookup: level end read (below the top level), level start read,
// bindings scanned in turn (single read port of the binding store), then lower levels likewise;
// prefix 0, bad level, pop when empty: at decode; one transaction in work at a time, the next
// taken the cycle after its result is loaded; reset (async, active low) empties the stack and
// clears the config register; the level and binding stores are not cleared
module scoped_prefix_map_stack_top
  import spms_pkg::*;
#(
  parameter int MAX_LEVELS   = 64,
  parameter int MAX_BINDINGS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spms_req_t           in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spms_rsp_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [URI_BITS-1:0] cfg_data_i
);

  spms_cmd_t  cmd;
  spms_stat_t stat;

  assign cfg_ready_o = 1'b1;

  spms_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  spms_dp #(
    .MAX_LEVELS  (MAX_LEVELS),
    .MAX_BINDINGS(MAX_BINDINGS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

/* design/spms_checker.sv */
`include "scoped_prefix_map_stack_top_assert.svh"

module spms_checker
  import spms_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input spms_rsp_t out_data_o
);

  logic [1:0] pend_q, pend_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // transactions taken but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `SPMS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `SPMS_ASSERT_IMPL(a_out_has_source, out_valid_o, pend_q != 2'd0)
  `SPMS_ASSERT_IMPL(a_pend_bound, 1'b1, pend_q != 2'd3)
  `SPMS_ASSERT_IMPL(a_match_clean, out_valid_o && out_data_o.matched, out_data_o.status == ST_OK && out_data_o.level_index == '0)

endmodule

bind scoped_prefix_map_stack_top spms_checker u_checker (.*);
